// ===== hdl/wu_pkg.sv =====
package wu_pkg;

    localparam int IMG_WIDTH = 256;
    localparam int IMG_HEIGHT = 256;
    localparam int COORD_FRAC_BITS = 6;
    localparam int COL_W = $clog2(IMG_WIDTH);
    localparam int ROW_W = $clog2(IMG_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int PIX_W = 17;
    localparam logic [PIX_W-1:0] PIX_ONE = 17'd65536;
    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] PLOT_CAP = 12'd4095;
    localparam int POS_W = 28;
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_DRAW  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        req_t        kind;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] color;
        logic [9:0]  pcol;
        logic [9:0]  prow;
        logic [16:0] pval;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] read_value;
        logic [CNT_W-1:0] plots_done;
        logic             clipped;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_PLOT,
        ST_RD,
        ST_WAIT,
        ST_WR,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/wu_line_accumulate_raster.sv =====
// Wu antialiased line raster over a 256x256 Q1.16 intensity image held in one
// single-port-write, registered-read RAM. Each request returns one result
// transaction. A read or write passes a RAM wait state before it completes; a
// draw runs setup and, for a sloped line, a slope division, then reads, waits on
// and writes back each plot inside the image and drops each plot outside it
// without the wait. The image is not cleared on reset; write every pixel before
// reading it.
module wu_line_accumulate_raster (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tuser: req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    // tdata: start_col, start_row, end_col, end_row, line_color, pix_col,
    // pix_row, pix_value, zero pad
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: read_value, plots_done, clipped, zero pad
    output logic [31:0]  m_axis_tdata
);

    wu_pkg::item_t   in_item, q_item;
    wu_pkg::result_t res;
    logic            q_valid, q_ready;

    assign in_item.kind  = wu_pkg::req_t'(s_axis_tuser);
    assign in_item.x0    = s_axis_tdata[15:0];
    assign in_item.y0    = s_axis_tdata[31:16];
    assign in_item.x1    = s_axis_tdata[47:32];
    assign in_item.y1    = s_axis_tdata[63:48];
    assign in_item.color = s_axis_tdata[79:64];
    assign in_item.pcol  = s_axis_tdata[89:80];
    assign in_item.prow  = s_axis_tdata[99:90];
    assign in_item.pval  = s_axis_tdata[116:100];

    wu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_item (q_item)
    );

    wu_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_res  (res)
    );

    assign m_axis_tdata = {2'b00, res.clipped, res.plots_done, res.read_value};

endmodule

// ===== hdl/wu_ram.sv =====
module wu_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/wu_queue.sv =====
module wu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wu_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output wu_pkg::item_t out_item
);

    wu_pkg::item_t mem_reg [wu_pkg::Q_DEPTH];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'(wu_pkg::Q_DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/wu_engine.sv =====
module wu_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  wu_pkg::item_t   in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output wu_pkg::result_t out_res
);

    localparam int F = wu_pkg::COORD_FRAC_BITS;
    localparam int SH = 16 - F;

    wu_pkg::state_t state_reg, state_next;
    wu_pkg::item_t  it_reg;

    logic              mode_run_reg, mode_run_next;
    logic              major_x_reg, major_x_next;
    logic signed [17:0] a_reg, a_next, a_end_reg, a_end_next;
    logic signed [17:0] b_fix_reg, b_fix_next;
    logic [1:0]        phase_reg, phase_next;
    logic              side_reg, side_next;
    logic [16:0]       a0_reg, a0_next, a1_reg, a1_next;
    logic [16:0]       b0_reg, b0_next, b1_reg, b1_next;
    logic              neg_reg, neg_next;
    logic [15:0]       color_reg, color_next;
    logic [32:0]       rem_reg, rem_next;
    logic [16:0]       divd_reg, divd_next;
    logic [31:0]       quo_reg, quo_next;
    logic [5:0]        dcnt_reg, dcnt_next;
    logic signed [wu_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [wu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic              clip_reg, clip_next;
    logic [16:0]       w_reg, w_next;
    logic [wu_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    wu_pkg::result_t   res_reg, res_next;

    logic              we;
    logic [16:0]       wdata;
    logic [wu_pkg::ADDR_W-1:0] raddr;
    logic [16:0]       rdata;

    wu_ram #(.WIDTH(wu_pkg::PIX_W), .DEPTH(wu_pkg::DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(addr_reg),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic signed [17:0] pc, pr;
    logic signed [wu_pkg::POS_W-1:0] ipos;
    logic [31:0] prod;
    logic [15:0] lo;
    logic [17:0] sum;
    logic [32:0] trial;

    assign in_ready  = (state_reg == wu_pkg::ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign ipos      = pos_reg >>> 16;
    assign prod      = pos_reg[15:0] * color_reg;
    assign lo        = prod[31:16];
    assign sum       = {1'b0, rdata} + {1'b0, w_reg};
    assign trial     = {rem_reg[31:0], divd_reg[16]} - {16'd0, a1_reg - a0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            it_reg <= in_item;
        end
        mode_run_reg <= mode_run_next;
        major_x_reg  <= major_x_next;
        a_reg        <= a_next;
        a_end_reg    <= a_end_next;
        b_fix_reg    <= b_fix_next;
        phase_reg    <= phase_next;
        side_reg     <= side_next;
        a0_reg       <= a0_next;
        a1_reg       <= a1_next;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        neg_reg      <= neg_next;
        color_reg    <= color_next;
        rem_reg      <= rem_next;
        divd_reg     <= divd_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        clip_reg     <= clip_next;
        w_reg        <= w_next;
        addr_reg     <= addr_next;
        res_reg      <= res_next;
    end

    // current plot coordinates and weight
    logic signed [17:0] pmaj, pmin;
    logic [15:0]        pw;
    always_comb
    begin
        pmaj = a_reg;
        pmin = b_fix_reg;
        pw   = color_reg;
        if (!mode_run_reg)
        begin
            case (phase_reg)
                2'd0:
                begin
                    pmaj = 18'(a0_reg >> F);
                    pmin = 18'(b0_reg >> F);
                end
                2'd1:
                begin
                    pmin = side_reg ? 18'(ipos + 1) : 18'(ipos);
                    pw   = side_reg ? lo : 16'(color_reg - lo);
                end
                default:
                begin
                    pmaj = 18'(a1_reg >> F);
                    pmin = 18'(b1_reg >> F);
                end
            endcase
        end
        pc = major_x_reg ? pmaj : pmin;
        pr = major_x_reg ? pmin : pmaj;
    end

    logic [16:0] dx, dy, lo_v, hi_v;
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mode_run_next  = mode_run_reg;
        major_x_next   = major_x_reg;
        a_next         = a_reg;
        a_end_next     = a_end_reg;
        b_fix_next     = b_fix_reg;
        phase_next     = phase_reg;
        side_next      = side_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        neg_next       = neg_reg;
        color_next     = color_reg;
        rem_next       = rem_reg;
        divd_next      = divd_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        clip_next      = clip_reg;
        w_next         = w_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        we             = 1'b0;
        wdata          = (sum > 18'(wu_pkg::PIX_ONE)) ? wu_pkg::PIX_ONE : sum[16:0];
        raddr          = addr_reg;
        dx = (it_reg.x1 > it_reg.x0) ? 17'(it_reg.x1 - it_reg.x0) : 17'(it_reg.x0 - it_reg.x1);
        dy = (it_reg.y1 > it_reg.y0) ? 17'(it_reg.y1 - it_reg.y0) : 17'(it_reg.y0 - it_reg.y1);
        lo_v = 17'd0;
        hi_v = 17'd0;
        case (state_reg)
            wu_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cnt_next  = '0;
                    clip_next = 1'b0;
                    case (in_item.kind)
                        wu_pkg::REQ_DRAW: state_next = wu_pkg::ST_SETUP;
                        wu_pkg::REQ_READ, wu_pkg::REQ_WRITE:
                        begin
                            addr_next = wu_pkg::ADDR_W'(
                                {in_item.prow[wu_pkg::ROW_W-1:0],
                                 in_item.pcol[wu_pkg::COL_W-1:0]});
                            if (32'(in_item.pcol) >= wu_pkg::IMG_WIDTH ||
                                32'(in_item.prow) >= wu_pkg::IMG_HEIGHT)
                            begin
                                clip_next  = 1'b1;
                                state_next = wu_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = wu_pkg::ST_READ_WAIT;
                            end
                        end
                        default: state_next = wu_pkg::ST_DONE;
                    endcase
                end
            end
            wu_pkg::ST_READ_WAIT:
            begin
                state_next = wu_pkg::ST_READ_DONE;
            end
            wu_pkg::ST_READ_DONE:
            begin
                if (it_reg.kind == wu_pkg::REQ_WRITE)
                begin
                    we    = 1'b1;
                    wdata = (it_reg.pval > wu_pkg::PIX_ONE) ? wu_pkg::PIX_ONE : it_reg.pval;
                    state_next = wu_pkg::ST_DONE;
                end
                else
                begin
                    res_next.read_value = rdata;
                    res_next.plots_done = '0;
                    res_next.clipped    = 1'b0;
                    out_valid_next      = 1'b1;
                    state_next          = wu_pkg::ST_IDLE;
                end
            end
            wu_pkg::ST_SETUP:
            begin
                color_next = it_reg.color;
                if (dx == 17'd0 || dy == 17'd0)
                begin
                    mode_run_next = 1'b1;
                    major_x_next  = (dx != 17'd0);
                    if (dx == 17'd0)
                    begin
                        lo_v = (it_reg.y0 < it_reg.y1) ? 17'(it_reg.y0) : 17'(it_reg.y1);
                        hi_v = (it_reg.y0 < it_reg.y1) ? 17'(it_reg.y1) : 17'(it_reg.y0);
                        b_fix_next = 18'(it_reg.x0 >> F);
                    end
                    else
                    begin
                        lo_v = (it_reg.x0 < it_reg.x1) ? 17'(it_reg.x0) : 17'(it_reg.x1);
                        hi_v = (it_reg.x0 < it_reg.x1) ? 17'(it_reg.x1) : 17'(it_reg.x0);
                        b_fix_next = 18'(it_reg.y0 >> F);
                    end
                    a_next     = 18'(lo_v >> F);
                    a_end_next = 18'(hi_v >> F);
                    state_next = wu_pkg::ST_RD;
                end
                else
                begin
                    mode_run_next = 1'b0;
                    major_x_next  = (dy < dx);
                    if (dy < dx)
                    begin
                        if (it_reg.x1 < it_reg.x0)
                        begin
                            a0_next = 17'(it_reg.x1); b0_next = 17'(it_reg.y1);
                            a1_next = 17'(it_reg.x0); b1_next = 17'(it_reg.y0);
                        end
                        else
                        begin
                            a0_next = 17'(it_reg.x0); b0_next = 17'(it_reg.y0);
                            a1_next = 17'(it_reg.x1); b1_next = 17'(it_reg.y1);
                        end
                    end
                    else
                    begin
                        if (it_reg.y1 < it_reg.y0)
                        begin
                            a0_next = 17'(it_reg.y1); b0_next = 17'(it_reg.x1);
                            a1_next = 17'(it_reg.y0); b1_next = 17'(it_reg.x0);
                        end
                        else
                        begin
                            a0_next = 17'(it_reg.y0); b0_next = 17'(it_reg.x0);
                            a1_next = 17'(it_reg.y1); b1_next = 17'(it_reg.x1);
                        end
                    end
                    neg_next  = (b1_next < b0_next);
                    divd_next = (b1_next < b0_next) ? 17'(b0_next - b1_next)
                                                    : 17'(b1_next - b0_next);
                    rem_next  = '0;
                    quo_next  = '0;
                    dcnt_next = '0;
                    state_next = wu_pkg::ST_DIV;
                end
            end
            wu_pkg::ST_DIV:
            begin
                // restoring division of db<<16 by da, one bit per cycle
                if (!trial[32])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], divd_reg[16]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                divd_next = {divd_reg[15:0], 1'b0};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd33)
                begin
                    rem_next  = rem_reg;
                    quo_next  = quo_reg;
                    pos_next  = neg_reg
                        ? wu_pkg::POS_W'($signed({11'd0, b0_reg} << SH) - $signed({1'b0, quo_reg[26:0]}))
                        : wu_pkg::POS_W'($signed({11'd0, b0_reg} << SH) + $signed({1'b0, quo_reg[26:0]}));
                    if (neg_reg)
                    begin
                        quo_next = 32'(-$signed(quo_reg));
                    end
                    phase_next = 2'd0;
                    side_next  = 1'b0;
                    a_next     = 18'(a0_reg >> F) + 18'sd1;
                    state_next = wu_pkg::ST_RD;
                end
            end
            wu_pkg::ST_RD:
            begin
                w_next  = 17'(pw);
                if (cnt_reg != wu_pkg::PLOT_CAP)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                addr_next = wu_pkg::ADDR_W'({pr[wu_pkg::ROW_W-1:0], pc[wu_pkg::COL_W-1:0]});
                raddr     = addr_next;
                if (pc < 0 || pr < 0 || pc >= 18'(wu_pkg::IMG_WIDTH) ||
                    pr >= 18'(wu_pkg::IMG_HEIGHT))
                begin
                    clip_next  = 1'b1;
                    state_next = wu_pkg::ST_WR;
                    w_next     = 17'd0;
                    addr_next  = addr_reg;
                end
                else
                begin
                    state_next = wu_pkg::ST_WAIT;
                end
                if (!mode_run_reg && phase_reg == 2'd1)
                begin
                    w_next = (pc < 0 || pr < 0 || pc >= 18'(wu_pkg::IMG_WIDTH) ||
                              pr >= 18'(wu_pkg::IMG_HEIGHT)) ? 17'd0
                           : 17'(side_reg ? lo : 16'(color_reg - lo));
                end
            end
            wu_pkg::ST_WAIT:
            begin
                state_next = wu_pkg::ST_WR;
            end
            wu_pkg::ST_WR:
            begin
                we = (w_reg != 17'd0) || !clip_reg || 1'b1;
                we = we && (state_reg == wu_pkg::ST_WR) &&
                     !(pc < 0 || pr < 0 || pc >= 18'(wu_pkg::IMG_WIDTH) ||
                       pr >= 18'(wu_pkg::IMG_HEIGHT));
                state_next = wu_pkg::ST_RD;
                if (mode_run_reg)
                begin
                    a_next = a_reg + 18'sd1;
                    if (a_reg == a_end_reg)
                    begin
                        state_next = wu_pkg::ST_DONE;
                    end
                end
                else
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            phase_next = ($signed({a_reg, 6'd0} >>> (6 - F)) <
                                          $signed({7'd0, a1_reg})) ? 2'd1 : 2'd2;
                        end
                        2'd1:
                        begin
                            side_next = ~side_reg;
                            if (side_reg)
                            begin
                                pos_next = pos_reg + wu_pkg::POS_W'($signed(quo_reg));
                                a_next   = a_reg + 18'sd1;
                                if (!($signed(({a_reg + 18'sd1, 6'd0}) >>> (6 - F)) <
                                      $signed({7'd0, a1_reg})))
                                begin
                                    phase_next = 2'd2;
                                end
                            end
                        end
                        default: state_next = wu_pkg::ST_DONE;
                    endcase
                end
            end
            wu_pkg::ST_DONE:
            begin
                res_next.read_value = '0;
                res_next.plots_done = cnt_reg;
                res_next.clipped    = clip_reg;
                out_valid_next      = 1'b1;
                state_next          = wu_pkg::ST_IDLE;
            end
            default: state_next = wu_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/wu_checker.sv =====
module wu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
        else $error("pad bits set");

    a_rv: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536)
        else $error("read value above one");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16:0] != 17'd0 |-> m_axis_tdata[28:17] == 12'd0)
        else $error("read result carries plot count");

endmodule

bind wu_line_accumulate_raster wu_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== tb/sv/tb_wu_line_accumulate_raster.sv =====
module tb_wu_line_accumulate_raster;
    import wu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 145;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;

    typedef struct {
        item_t   req;
        bit      typed;
        result_t res;
    } stim_row_t;

    logic [PIX_W-1:0] image_mirror [DEPTH];
    bit               pixel_written [DEPTH];
    int unsigned      plot_tally;
    bit               plot_clipped;
    bit               collect_only;
    int               touched_pixels [$];
    result_t          pending_results [$];
    stim_row_t        directed_rows [$];
    int               send_gap_pct;
    int               stall_pct;
    int               mismatches;
    int               idle_cycles;

    wu_line_accumulate_raster u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic plot_pixel(longint c, longint r, longint w);
        int     idx;
        longint v;
        if (plot_tally < 4095)
            plot_tally++;
        if (c < 0 || r < 0 || c >= IMG_WIDTH || r >= IMG_HEIGHT)
        begin
            plot_clipped = 1'b1;
            return;
        end
        idx = int'(r * IMG_WIDTH + c);
        if (collect_only)
            touched_pixels.insert(touched_pixels.size(), idx);
        else
        begin
            v = longint'(image_mirror[idx]) + w;
            if (v > 65536)
                v = 65536;
            image_mirror[idx] = v[PIX_W-1:0];
        end
    endtask

    task automatic plot_axis(bit major_x, longint a, longint b, longint w);
        if (major_x)
            plot_pixel(a, b, w);
        else
            plot_pixel(b, a, w);
    endtask

    task automatic walk_major(bit major_x, longint a0, longint b0, longint a1, longint b1,
                              longint color);
        longint da, db, grad, pos, a, ip, fr, lo;
        da = a1 - a0;
        db = (b1 > b0) ? (b1 - b0) : (b0 - b1);
        grad = (db * 65536) / da;
        if (b1 < b0)
            grad = -grad;
        pos = b0 * (longint'(1) << (16 - COORD_FRAC_BITS)) + grad;
        plot_axis(major_x, a0 >>> COORD_FRAC_BITS, b0 >>> COORD_FRAC_BITS, color);
        for (a = (a0 >>> COORD_FRAC_BITS) + 1; (a <<< COORD_FRAC_BITS) < a1; a++)
        begin
            ip = pos >>> 16;
            fr = pos & 64'hFFFF;
            lo = (fr * color) >> 16;
            plot_axis(major_x, a, ip, color - lo);
            plot_axis(major_x, a, ip + 1, lo);
            pos += grad;
        end
        plot_axis(major_x, a1 >>> COORD_FRAC_BITS, b1 >>> COORD_FRAC_BITS, color);
    endtask

    task automatic raster_line(longint x0, longint y0, longint x1, longint y1, longint color);
        longint dx, dy, i, lo, hi;
        dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        if (dx == 0)
        begin
            lo = ((y0 < y1) ? y0 : y1) >>> COORD_FRAC_BITS;
            hi = ((y0 < y1) ? y1 : y0) >>> COORD_FRAC_BITS;
            for (i = lo; i <= hi; i++)
                plot_pixel(x0 >>> COORD_FRAC_BITS, i, color);
        end
        else if (dy == 0)
        begin
            lo = ((x0 < x1) ? x0 : x1) >>> COORD_FRAC_BITS;
            hi = ((x0 < x1) ? x1 : x0) >>> COORD_FRAC_BITS;
            for (i = lo; i <= hi; i++)
                plot_pixel(i, y0 >>> COORD_FRAC_BITS, color);
        end
        else if (dy < dx)
        begin
            if (x1 < x0)
                walk_major(1'b1, x1, y1, x0, y0, color);
            else
                walk_major(1'b1, x0, y0, x1, y1, color);
        end
        else
        begin
            if (y1 < y0)
                walk_major(1'b0, y1, x1, y0, x0, color);
            else
                walk_major(1'b0, y0, x0, y1, x1, color);
        end
    endtask

    task automatic raster_request(item_t it, output result_t res);
        int idx;
        plot_tally = 0;
        plot_clipped = 1'b0;
        res = '0;
        case (it.kind)
            REQ_DRAW:
                raster_line(it.x0, it.y0, it.x1, it.y1, it.color);
            REQ_READ, REQ_WRITE:
            begin
                if (it.pcol >= IMG_WIDTH || it.prow >= IMG_HEIGHT)
                    plot_clipped = 1'b1;
                else
                begin
                    idx = int'(it.prow) * IMG_WIDTH + int'(it.pcol);
                    if (it.kind == REQ_READ)
                        res.read_value = image_mirror[idx];
                    else
                    begin
                        image_mirror[idx] = (it.pval > PIX_ONE) ? PIX_ONE : it.pval;
                        pixel_written[idx] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.plots_done = plot_tally[CNT_W-1:0];
        res.clipped = plot_clipped;
    endtask

    task automatic issue_request(item_t it, bit typed, result_t typed_res);
        result_t predicted;
        raster_request(it, predicted);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.kind;
        s_axis_tdata <= {3'b000, it.pval, it.prow, it.pcol, it.color, it.y1, it.x1, it.y0,
                         it.x0};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic item_t pixel_write(int idx, logic [16:0] value);
        item_t w;
        w = '0;
        w.kind = REQ_WRITE;
        w.pcol = 10'(idx % IMG_WIDTH);
        w.prow = 10'(idx / IMG_WIDTH);
        w.pval = value;
        return w;
    endfunction

    task automatic send_request(item_t it, bit typed, result_t typed_res);
        result_t unused;
        int      idx;
        if (it.kind == REQ_DRAW)
        begin
            collect_only = 1'b1;
            touched_pixels.delete();
            raster_request(it, unused);
            collect_only = 1'b0;
            foreach (touched_pixels[k])
                if (!pixel_written[touched_pixels[k]])
                    issue_request(pixel_write(touched_pixels[k], '0), 1'b0, '0);
        end
        else if (it.kind == REQ_READ && it.pcol < IMG_WIDTH && it.prow < IMG_HEIGHT)
        begin
            idx = int'(it.prow) * IMG_WIDTH + int'(it.pcol);
            if (!pixel_written[idx])
                issue_request(pixel_write(idx, 17'($urandom_range(65536))), 1'b0, '0);
        end
        issue_request(it, typed, typed_res);
    endtask

    function automatic stim_row_t make_row(req_t kind, int x0, int y0, int x1, int y1,
                                           int color, int pcol, int prow, int pval,
                                           bit typed, int rv, int plots, bit clip);
        stim_row_t r;
        r.req = '{kind: kind, x0: 16'(x0), y0: 16'(y0), x1: 16'(x1), y1: 16'(y1),
                  color: 16'(color), pcol: 10'(pcol), prow: 10'(prow), pval: 17'(pval)};
        r.typed = typed;
        r.res = '{read_value: PIX_W'(rv), plots_done: CNT_W'(plots), clipped: clip};
        return r;
    endfunction

    task automatic queue_row(stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    function automatic item_t random_request();
        item_t it;
        int    pick;
        it.kind = REQ_DRAW;
        it.x0 = 16'($urandom);
        it.y0 = 16'($urandom);
        it.x1 = 16'($urandom);
        it.y1 = 16'($urandom);
        it.pcol = 10'($urandom);
        it.prow = 10'($urandom);
        it.pval = 17'($urandom);
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: it.color = 16'hFFFF;
            1: it.color = 16'($urandom_range(255));
            default: it.color = 16'($urandom);
        endcase
        if (pick < 50)
        begin
            if ($urandom_range(99) < 85)
            begin
                it.x0 = 16'($urandom_range(16 * 64 - 1));
                it.y0 = 16'($urandom_range(16 * 64 - 1));
                it.x1 = 16'($urandom_range(16 * 64 - 1));
                it.y1 = 16'($urandom_range(16 * 64 - 1));
                case ($urandom_range(9))
                    0: it.x1 = it.x0;
                    1: it.y1 = it.y0;
                    2: {it.x1, it.y1} = {it.x0, it.y0};
                    default: ;
                endcase
            end
            else
            begin
                it.x0 = 16'(IMG_WIDTH * 64 + $urandom_range(65535 - IMG_WIDTH * 64));
                it.x1 = 16'(IMG_WIDTH * 64 + $urandom_range(65535 - IMG_WIDTH * 64));
            end
        end
        else
        begin
            if (pick < 80)
                it.kind = REQ_READ;
            else if (pick < 95)
                it.kind = REQ_WRITE;
            else
                it.kind = REQ_NONE;
            if ($urandom_range(99) < 75)
            begin
                it.pcol = 10'($urandom_range(15));
                it.prow = 10'($urandom_range(15));
            end
            if ($urandom_range(99) < 70)
                it.pval = 17'($urandom_range(65536));
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        logic [PIX_W-1:0] got_value;
        logic [CNT_W-1:0] got_plots;
        logic             got_clip;
        result_t          want;
        got_value = m_axis_tdata[16:0];
        got_plots = m_axis_tdata[28:17];
        got_clip = m_axis_tdata[29];
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: value %0d plots %0d clip %0d",
                             got_value, got_plots, got_clip);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got_value !== want.read_value || got_plots !== want.plots_done
                    || got_clip !== want.clipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value %0d/%0d plots %0d/%0d clip %0d/%0d",
                                 want.read_value, got_value, want.plots_done, got_plots,
                                 want.clipped, got_clip);
                end
            end
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("wu_line_accumulate_raster verification failed");
            $finish;
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_gap_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        collect_only = 1'b0;
        foreach (pixel_written[i])
            pixel_written[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_row(make_row(REQ_WRITE, 0, 0, 0, 0, 0, 3, 3, 'h1FFFF, 1, 0, 0, 0));
        queue_row(make_row(REQ_READ, 0, 0, 0, 0, 0, 3, 3, 0, 1, 65536, 0, 0));
        queue_row(make_row(REQ_READ, 0, 0, 0, 0, 0, 1023, 0, 0, 1, 0, 0, 1));
        queue_row(make_row(REQ_WRITE, 0, 0, 0, 0, 0, 0, 1023, 5, 1, 0, 0, 1));
        queue_row(make_row(REQ_NONE, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                           1023, 1023, 'h1FFFF, 1, 0, 0, 0));
        queue_row(make_row(REQ_WRITE, 0, 0, 0, 0, 0, 255, 255, 0, 1, 0, 0, 0));
        queue_row(make_row(REQ_READ, 0, 0, 0, 0, 0, 255, 255, 0, 1, 0, 0, 0));
        queue_row(make_row(REQ_WRITE, 0, 0, 0, 0, 0, 4, 4, 65536, 1, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 645, 645, 645, 645, 'hFFFF, 0, 0, 0,
                           1, 0, 1, 0));
        queue_row(make_row(REQ_DRAW, 320, 128, 320, 400, 'h8000, 0, 0, 0,
                           1, 0, 5, 0));
        queue_row(make_row(REQ_DRAW, 128, 1280, 600, 1280, 'h1234, 0, 0, 0,
                           1, 0, 8, 0));
        queue_row(make_row(REQ_DRAW, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                           0, 0, 0, 1, 0, 1, 1));
        queue_row(make_row(REQ_DRAW, 0, 1920, 'hFFFF, 1920, 'h0101, 0, 0, 0,
                           1, 0, 1024, 1));
        queue_row(make_row(REQ_DRAW, 77, 91, 1290, 470, 'hBEEF, 0, 0, 0,
                           0, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 1930, 2570, 1610, 650, 'h7777, 0, 0, 0,
                           0, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 2575, 333, 770, 601, 'hFFFF, 0, 0, 0,
                           0, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 16000, 16000, 17290, 16770, 'hC000,
                           0, 0, 0, 0, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 2000, 100, 2600, 3000, 0, 0, 0, 0,
                           0, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 77, 91, 1290, 470, 'hFFFF, 0, 0, 0,
                           0, 0, 0, 0));
        queue_row(make_row(REQ_DRAW, 77, 91, 1290, 470, 'hFFFF, 0, 0, 0,
                           0, 0, 0, 0));
        queue_row(make_row(REQ_READ, 0, 0, 0, 0, 0, 10, 4, 0, 0, 0, 0, 0));
        queue_row(make_row(REQ_READ, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0));

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 59; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 59; end
                default: begin send_gap_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request(), 1'b0, '0);
            if (phase == 1)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("wu_line_accumulate_raster verification clean");
        else
            $display("wu_line_accumulate_raster verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wu_pkg.sv
hdl/wu_ram.sv
hdl/wu_queue.sv
hdl/wu_engine.sv
hdl/wu_line_accumulate_raster.sv
hdl/wu_checker.sv
tb/sv/tb_wu_line_accumulate_raster.sv
